// ===== src/kts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the keyframe track sampler.
// No dependencies.
package kts_pkg;
    localparam int MaxKeys = 64;
    localparam int AddrW   = $clog2(MaxKeys);
    localparam int CntW    = AddrW + 1;

    localparam logic [1:0] StInterp = 2'd0;
    localparam logic [1:0] StFirst  = 2'd1;
    localparam logic [1:0] StLast   = 2'd2;
    localparam logic [1:0] StEmpty  = 2'd3;

    localparam logic OpLoad   = 1'b0;
    localparam logic OpSample = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  key_slot;
        logic [31:0] key_time;
        logic [31:0] key_x;
        logic [31:0] key_y;
        logic [31:0] key_z;
        logic [31:0] query_time;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_CHK0, S_SCAN, S_SCANW, S_DIV, S_MUL, S_MULW, S_ADD,
        S_LASTW, S_OUT
    } t_state;
endpackage

// ===== src/kts_key_ram.sv =====
`timescale 1ns / 1ps
// Key table: time and xyz value per key, one write and one registered read port.
// Depends on kts_pkg.
module kts_key_ram
    import kts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AddrW-1:0]  i_waddr,
    input  logic [127:0]      i_wdata,
    input  logic [AddrW-1:0]  i_raddr,
    output logic [127:0]      o_rdata
);
    logic [127:0] r_mem [MaxKeys];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/kts_frac_div.sv =====
`timescale 1ns / 1ps
// Restoring divider for the Q1.16 segment fraction, one quotient bit per cycle.
// Depends on kts_pkg.
module kts_frac_div
    import kts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quot
);
    // num <= den, so quotient of num<<16 fits 17 bits
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [16:0] r_quot;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_trial;

    assign w_trial = {r_rem, 1'b0} - {2'b0, r_den};
    assign n_rem   = w_trial[33] ? {r_rem[31:0], 1'b0} : w_trial[32:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_den  <= i_den;
                r_rem  <= {1'b0, i_num};
                r_quot <= '0;
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    // first bit: compare num itself (weight 2^16)
                    if ({1'b0, r_rem} >= {2'b0, r_den}) begin
                        r_rem  <= r_rem - {1'b0, r_den};
                        r_quot <= 17'd1;
                    end
                end else begin
                    r_rem  <= n_rem;
                    r_quot <= {r_quot[15:0], ~w_trial[33]};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_quot;
endmodule

// ===== src/keyframe_track_sampler_top.sv =====
`timescale 1ns / 1ps
// Keyframe track sampler: a load writes one key slot. A sample reads the key table
// (one synchronous port) one key at a time while it walks segments in order; for a
// query inside a segment it runs a fraction divider (skipped on zero-length segments)
// and three multiplies on one shared 33x17 multiplier.
// Results sit in an output register; one item is worked at a time.
// Depends on kts_pkg, kts_key_ram, kts_frac_div.
module keyframe_track_sampler_top
    import kts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_data,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata
);
    t_state r_state, n_state;
    logic [6:0]        r_count;
    logic [CntW-1:0]   w_n;
    logic [31:0]       r_q;
    logic [AddrW-1:0]  r_idx, n_idx, w_raddr;
    logic [127:0]      w_rd;
    logic [127:0]      r_k0;
    logic [1:0]        r_comp;
    logic [16:0]       w_quot;
    logic [16:0]       r_f;
    logic              w_div_done, w_div_start;
    logic signed [32:0] r_diff;
    logic signed [50:0] r_prod;
    logic [95:0]       r_res;
    logic [1:0]        r_status;
    logic              w_load_acc;
    logic [31:0]       w_t0, w_t1;
    logic [31:0]       w_v0, w_v1;

    assign w_n = (r_count > 7'(MaxKeys)) ? CntW'(MaxKeys) : CntW'(r_count);
    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign w_load_acc = i_valid && o_ready && (i_data.opcode == OpLoad);

    kts_key_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_acc),
        .i_waddr (i_data.key_slot[AddrW-1:0]),
        .i_wdata ({i_data.key_time, i_data.key_x, i_data.key_y, i_data.key_z}),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign w_t0 = r_k0[127:96];
    assign w_t1 = w_rd[127:96];
    assign w_div_start = (r_state == S_SCAN) && (r_q <= w_t1) && (w_t1 != w_t0);

    kts_frac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_q - w_t0),
        .i_den   (w_t1 - w_t0),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        unique case (r_comp)
            2'd0:    begin w_v0 = r_k0[95:64]; w_v1 = w_rd[95:64]; end
            2'd1:    begin w_v0 = r_k0[63:32]; w_v1 = w_rd[63:32]; end
            default: begin w_v0 = r_k0[31:0];  w_v1 = w_rd[31:0];  end
        endcase
    end

    // read address: next key during scan, else hold current pair's upper key
    assign w_raddr = n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_valid && o_ready && i_data.opcode == OpSample) begin
                    n_state = (w_n == '0) ? S_OUT : S_RD0;
                end
            end
            S_RD0:  n_state = S_CHK0;
            S_CHK0: begin
                if (w_n == CntW'(1) || r_q <= w_rd[127:96]) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = AddrW'(1);
                    n_state = S_SCANW;
                end
            end
            S_SCANW: n_state = S_SCAN;
            S_SCAN: begin
                if (r_q <= w_t1) begin
                    n_state = (w_t1 != w_t0) ? S_DIV : S_MUL;
                end else if (CntW'(r_idx) + CntW'(1) >= w_n) begin
                    n_state = S_LASTW;
                end else begin
                    n_idx   = r_idx + AddrW'(1);
                    n_state = S_SCANW;
                end
            end
            S_DIV:   if (w_div_done) n_state = S_MUL;
            S_MUL:   n_state = S_MULW;
            S_MULW:  n_state = S_ADD;
            S_ADD:   n_state = (r_comp == 2'd2) ? S_OUT : S_MUL;
            S_LASTW: n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) r_count <= i_cfg_wdata;
            if (r_state == S_OUT) o_valid <= 1'b1;
            else if (o_valid && i_ready) o_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_q <= i_data.query_time;
                r_status <= StEmpty;
                r_res <= '0;
            end
            S_CHK0: begin
                r_k0 <= w_rd;
                r_res <= w_rd[95:0];
                r_status <= StFirst;
            end
            S_SCAN: begin
                r_comp <= 2'd0;
                r_f    <= '0;
                if (r_q <= w_t1) begin
                    r_status <= StInterp;
                end else if (CntW'(r_idx) + CntW'(1) < w_n) begin
                    r_k0 <= w_rd;
                end
            end
            S_DIV: if (w_div_done) r_f <= w_quot;
            S_MUL: r_diff <= 33'(signed'(w_v1)) - 33'(signed'(w_v0));
            S_MULW: r_prod <= r_diff * signed'({1'b0, r_f});
            S_ADD: begin
                // arithmetic shift floors, matching floor division by 65536
                unique case (r_comp)
                    2'd0:    r_res[95:64] <= w_v0 + 32'(r_prod >>> 16);
                    2'd1:    r_res[63:32] <= w_v0 + 32'(r_prod >>> 16);
                    default: r_res[31:0]  <= w_v0 + 32'(r_prod >>> 16);
                endcase
                r_comp <= r_comp + 2'd1;
            end
            S_LASTW: begin
                r_res <= w_rd[95:0];
                r_status <= StLast;
            end
            S_OUT: begin
                o_data.out_x <= r_res[95:64];
                o_data.out_y <= r_res[63:32];
                o_data.out_z <= r_res[31:0];
                o_data.status <= r_status;
            end
            default: ;
        endcase
    end
endmodule

// ===== sim/keyframe_track_sampler_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for keyframe_track_sampler_top: directed table, then random
// load/sample phases checked against an in-bench track interpolation predictor.
// Depends on kts_pkg and the sampler RTL.
module keyframe_track_sampler_top_tb;
    import kts_pkg::*;

    localparam int WatchLimit = 6000;
    localparam int SettleCycles = 250;
    localparam int ItemTarget = 1500;

    typedef struct {
        bit        do_cfg;
        logic [6:0] cfg_val;
        t_in_item  item;
        bit        has_exp;
        t_out_item exp;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;
    logic      i_cfg_we = 1'b0;
    logic [6:0] i_cfg_wdata = '0;

    keyframe_track_sampler_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [31:0] key_time_tab [MaxKeys];
    logic [31:0] key_val_tab [MaxKeys][3];
    logic [6:0]  active_keys = '0;

    t_out_item sample_q[$];
    t_row      rows[$];
    int  errors = 0;
    int  idle_cnt = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  items_sent = 0;

    function automatic void add_row(t_row r);
        rows = {rows, r};
    endfunction

    function automatic t_out_item sample_track(logic [31:0] q);
        int n;
        logic [31:0] t0, t1;
        logic [63:0] num;
        longint f, v0, v1;
        logic [31:0] res [3];
        t_out_item r;
        n = (active_keys > MaxKeys) ? MaxKeys : active_keys;
        r = '0;
        if (n == 0) begin
            r.status = StEmpty;
            return r;
        end
        if (n == 1 || q <= key_time_tab[0]) begin
            r = '{key_val_tab[0][0], key_val_tab[0][1], key_val_tab[0][2], StFirst};
            return r;
        end
        for (int i = 0; i + 1 < n; i++) begin
            t0 = key_time_tab[i];
            t1 = key_time_tab[i+1];
            if (t0 <= q && q <= t1) begin
                f = 0;
                if (t1 != t0) begin
                    num = {16'b0, q - t0, 16'b0};
                    f = longint'(num / {32'b0, t1 - t0});
                end
                for (int c = 0; c < 3; c++) begin
                    v0 = longint'($signed(key_val_tab[i][c]));
                    v1 = longint'($signed(key_val_tab[i+1][c]));
                    res[c] = 32'(v0 + (((v1 - v0) * f) >>> 16));
                end
                r = '{res[0], res[1], res[2], StInterp};
                return r;
            end
        end
        r = '{key_val_tab[n-1][0], key_val_tab[n-1][1], key_val_tab[n-1][2], StLast};
        return r;
    endfunction

    function automatic t_in_item mk_load(int slot, logic [31:0] t,
                                         logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_in_item it;
        it = '{OpLoad, 6'(slot), t, x, y, z, $urandom};
        return it;
    endfunction

    function automatic t_in_item mk_sample(logic [31:0] q);
        t_in_item it;
        it = '{OpSample, 6'($urandom), $urandom, $urandom, $urandom, $urandom, q};
        return it;
    endfunction

    // one transfer on the input channel; called at a clock edge
    task automatic send_item(t_in_item it, bit has_exp, t_out_item exp);
        if (!quiet && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (it.opcode == OpLoad) begin
            key_time_tab[it.key_slot] = it.key_time;
            key_val_tab[it.key_slot][0] = it.key_x;
            key_val_tab[it.key_slot][1] = it.key_y;
            key_val_tab[it.key_slot][2] = it.key_z;
        end else begin
            sample_q = {sample_q, has_exp ? exp : sample_track(it.query_time)};
        end
    endtask

    // key count is only changed with the block drained
    task automatic set_count(logic [6:0] v);
        i_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        active_keys = v;
    endtask

    // result side: check, then choose ready for the next cycle
    always @(posedge i_clk) begin
        t_out_item exp;
        if (i_rst_n && o_valid && i_ready) begin
            if (sample_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                errors++;
            end else begin
                exp = sample_q.pop_front();
                if (o_data.out_x !== exp.out_x)
                    $display("%0t: out_x exp %h got %h", $time, exp.out_x, o_data.out_x);
                if (o_data.out_y !== exp.out_y)
                    $display("%0t: out_y exp %h got %h", $time, exp.out_y, o_data.out_y);
                if (o_data.out_z !== exp.out_z)
                    $display("%0t: out_z exp %h got %h", $time, exp.out_z, o_data.out_z);
                if (o_data.status !== exp.status)
                    $display("%0t: status exp %0d got %0d", $time, exp.status, o_data.status);
                if (o_data !== exp) errors++;
            end
        end
        if (hold_req && hold_left == 0) hold_left = 400;
        if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) hold_req = 1'b0;
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WatchLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_out_item none;
        t_row r;
        logic [31:0] t;
        int n, m;
        int last;
        none = '0;

        // directed: empty table, single key, clamps, extremes of value fields
        add_row('{1, 7'd0, mk_sample(32'h0), 1, '{0, 0, 0, StEmpty}});
        add_row('{0, 0, mk_sample(32'hFFFF_FFFF), 1, '{0, 0, 0, StEmpty}});
        add_row('{0, 0, mk_load(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0),
                  0, none});
        add_row('{0, 0, mk_load(1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1),
                  0, none});
        add_row('{1, 7'd1, mk_sample(32'hFFFF_FFFF), 1,
                  '{32'h7FFF_FFFF, 32'h8000_0000, 0, StFirst}});
        add_row('{1, 7'd2, mk_sample(32'h0), 1,
                  '{32'h7FFF_FFFF, 32'h8000_0000, 0, StFirst}});
        add_row('{0, 0, mk_sample(32'h0001_0000), 1,
                  '{32'h7FFF_FFFF, 32'h8000_0000, 0, StFirst}});
        add_row('{0, 0, mk_sample(32'h0001_0001), 0, none});
        add_row('{0, 0, mk_sample(32'h0002_0000), 0, none});
        add_row('{0, 0, mk_sample(32'h0002_FFFF), 0, none});
        add_row('{0, 0, mk_sample(32'h0003_0000), 0, none});
        add_row('{0, 0, mk_sample(32'hFFFF_FFFF), 1,
                  '{32'h8000_0000, 32'h7FFF_FFFF, 1, StLast}});
        // equal times: key 1 moved to key 0's time, making the only segment zero-length
        add_row('{0, 0, mk_load(1, 32'h0001_0000, 5, 6, 7), 0, none});
        add_row('{0, 0, mk_sample(32'h0001_0000), 0, none});
        add_row('{0, 0, mk_sample(32'h0001_0001), 1, '{5, 6, 7, StLast}});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            r = rows[k];
            if (r.do_cfg) set_count(r.cfg_val);
            send_item(r.item, r.has_exp, r.exp);
        end

        // random phases: table load in rising time order (sums may wrap), then samples and some noise
        for (int ph = 0; items_sent < ItemTarget; ph++) begin
            case ($urandom_range(5))
                0: n = 1;
                1: n = 2;
                2: n = 64;
                3: n = $urandom_range(65, 127);
                4: n = 0;
                default: n = $urandom_range(2, 64);
            endcase
            if (ph == 0) n = 64;
            quiet = (ph >= 4 && ph < 7);
            m = (n > MaxKeys) ? MaxKeys : n;
            if (ph == 0) m = MaxKeys;
            last = (m == 0) ? 0 : m - 1;
            t = ($urandom_range(3) == 0) ? 32'h0 : $urandom_range(0, 32'h00FF_FFFF);
            set_count(7'(n));
            for (int s = 0; s < m; s++) begin
                if (s > 0 && $urandom_range(7) != 0)
                    t = t + (($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 32'h3_0000));
                if (s == m - 1 && $urandom_range(3) == 0) t = 32'hFFFF_FFFF;
                send_item(mk_load(s, t,
                    ($urandom_range(9) == 0) ? 32'h8000_0000 : $urandom,
                    ($urandom_range(9) == 0) ? 32'h7FFF_FFFF : $urandom,
                    $urandom), 0, none);
            end
            if (ph == 2) hold_req = 1'b1;
            for (int s = 0; s < 30; s++) begin
                case ($urandom_range(9))
                    0: send_item(mk_sample($urandom), 0, none);
                    1: send_item(mk_sample(key_time_tab[$urandom_range(last)]), 0, none);
                    2: send_item(mk_load($urandom_range(63), $urandom, $urandom, $urandom,
                                         $urandom), 0, none);
                    3: send_item(mk_sample(32'hFFFF_FFFF), 0, none);
                    default: send_item(mk_sample(key_time_tab[0] +
                        $urandom_range(0, key_time_tab[last] - key_time_tab[0] + 16)),
                        0, none);
                endcase
            end
        end
        quiet = 1'b0;
        i_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/kts_pkg.sv
src/kts_key_ram.sv
src/kts_frac_div.sv
src/keyframe_track_sampler_top.sv
sim/keyframe_track_sampler_top_tb.sv
